[src/cnft_pkg.sv]
package cnft_pkg;

    localparam int unsigned YEAR_BITS = 128;

    // register indexes of the configuration port
    localparam logic [3:0] REG_MINUTE    = 4'd0;
    localparam logic [3:0] REG_HOUR      = 4'd1;
    localparam logic [3:0] REG_MDAY      = 4'd2;
    localparam logic [3:0] REG_MONTH     = 4'd3;
    localparam logic [3:0] REG_WDAY      = 4'd4;
    localparam logic [3:0] REG_YEAR_LOW  = 4'd5;
    localparam logic [3:0] REG_YEAR_HIGH = 4'd6;
    localparam logic [3:0] REG_MDAY_ANY  = 4'd7;

    localparam logic [4:0] LAST_WDAY = 5'd6;
    localparam logic [3:0] DEC       = 4'd11;
    localparam logic [3:0] FEB       = 4'd1;
    localparam logic [3:0] NUM_MON   = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE, S_MAIN, S_MIN, S_HOUR, S_DAY, S_MDAY,
        S_MON, S_YEAR, S_WALK, S_RET, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_START, PH_DAYCHK, PH_HRCHK, PH_MINCHK, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        DS_MDAY, DS_YEAR, DS_MON, DS_MDAY2, DS_END
    } t_dstep;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_FIND_MIN, OP_FIND_HOUR, OP_FIND_MDAY,
        OP_FIND_MON, OP_FIND_YEAR, OP_CLR_HM, OP_CLR_MIN, OP_SET_JAN1,
        OP_SET_D1, OP_MDAY_STEP, OP_WALK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
        logic never;
    } t_cmd;

    typedef struct packed {
        logic find_none;
        logic find_ovf;
        logic day_ok;
        logic hour_hit;
        logic min_hit;
        logic year_ok;
        logic mon_ok;
        logic mday_ok;
        logic wday_used;
        logic mday_any;
        logic mday_end;
        logic walk_ok;
        logic out_busy;
    } t_stat;

    // days in month, leap february handled by the caller
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        unique case (mon)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[src/cnft_ctrl.sv]
module cnft_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_ready,
    input  cnft_pkg::t_stat i_stat,
    output cnft_pkg::t_cmd  o_cmd
);

    cnft_pkg::t_state r_state, n_state;
    cnft_pkg::t_phase r_phase, n_phase;
    cnft_pkg::t_dstep r_dstep, n_dstep;
    logic             r_day_act, n_day_act;
    logic             r_fail, n_fail;
    logic [2:0]       r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cnft_pkg::S_IDLE;
            r_phase   <= cnft_pkg::PH_START;
            r_dstep   <= cnft_pkg::DS_MDAY;
            r_day_act <= 1'b0;
            r_fail    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_dstep   <= n_dstep;
            r_day_act <= n_day_act;
            r_fail    <= n_fail;
            r_cnt     <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_dstep      = r_dstep;
        n_day_act    = r_day_act;
        n_fail       = r_fail;
        n_cnt        = r_cnt;
        o_cmd.op       = cnft_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        o_cmd.never    = r_fail;
        o_ready      = (r_state == cnft_pkg::S_IDLE);
        unique case (r_state)
            cnft_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.op  = cnft_pkg::OP_LOAD;
                    n_phase   = cnft_pkg::PH_START;
                    n_day_act = 1'b0;
                    n_fail    = 1'b0;
                    n_state   = cnft_pkg::S_MAIN;
                end
            end
            cnft_pkg::S_MAIN: begin
                unique case (r_phase)
                    cnft_pkg::PH_START: begin
                        n_phase = cnft_pkg::PH_DAYCHK;
                        n_state = cnft_pkg::S_MIN;
                    end
                    cnft_pkg::PH_DAYCHK: begin
                        n_phase = cnft_pkg::PH_HRCHK;
                        if (!i_stat.day_ok) begin
                            o_cmd.op = cnft_pkg::OP_CLR_HM;
                            n_dstep  = cnft_pkg::DS_MDAY;
                            n_state  = cnft_pkg::S_DAY;
                        end
                    end
                    cnft_pkg::PH_HRCHK: begin
                        n_phase = cnft_pkg::PH_MINCHK;
                        if (!i_stat.hour_hit) begin
                            o_cmd.op = cnft_pkg::OP_CLR_MIN;
                            n_state  = cnft_pkg::S_HOUR;
                        end
                    end
                    cnft_pkg::PH_MINCHK: begin
                        n_phase = cnft_pkg::PH_DONE;
                        if (!i_stat.min_hit) n_state = cnft_pkg::S_MIN;
                    end
                    default: n_state = cnft_pkg::S_OUT;
                endcase
            end
            cnft_pkg::S_MIN: begin
                o_cmd.op = cnft_pkg::OP_FIND_MIN;
                if (i_stat.find_none) begin
                    n_fail  = 1'b1;
                    n_state = cnft_pkg::S_OUT;
                end else if (i_stat.find_ovf) begin
                    n_state = cnft_pkg::S_HOUR;
                end else begin
                    n_state = cnft_pkg::S_RET;
                end
            end
            cnft_pkg::S_HOUR: begin
                o_cmd.op = cnft_pkg::OP_FIND_HOUR;
                if (i_stat.find_none) begin
                    n_fail  = 1'b1;
                    n_state = cnft_pkg::S_OUT;
                end else if (i_stat.find_ovf) begin
                    n_dstep = cnft_pkg::DS_MDAY;
                    n_state = cnft_pkg::S_DAY;
                end else begin
                    n_state = cnft_pkg::S_RET;
                end
            end
            cnft_pkg::S_DAY: begin
                if (i_stat.wday_used) begin
                    n_cnt   = '0;
                    n_state = cnft_pkg::S_WALK;
                end else begin
                    unique case (r_dstep)
                        cnft_pkg::DS_MDAY: begin
                            n_day_act = 1'b1;
                            n_dstep   = cnft_pkg::DS_YEAR;
                            n_state   = cnft_pkg::S_MDAY;
                        end
                        cnft_pkg::DS_YEAR: begin
                            n_dstep = cnft_pkg::DS_MON;
                            if (!i_stat.year_ok) begin
                                o_cmd.op = cnft_pkg::OP_SET_JAN1;
                                n_state  = cnft_pkg::S_YEAR;
                            end
                        end
                        cnft_pkg::DS_MON: begin
                            n_dstep = cnft_pkg::DS_MDAY2;
                            if (!i_stat.mon_ok) begin
                                o_cmd.op = cnft_pkg::OP_SET_D1;
                                n_state  = cnft_pkg::S_MON;
                            end
                        end
                        cnft_pkg::DS_MDAY2: begin
                            n_dstep = cnft_pkg::DS_END;
                            if (!i_stat.mday_ok) n_state = cnft_pkg::S_MDAY;
                        end
                        default: begin
                            n_day_act = 1'b0;
                            n_state   = cnft_pkg::S_MAIN;
                        end
                    endcase
                end
            end
            cnft_pkg::S_MDAY: begin
                if (i_stat.mday_any) begin
                    o_cmd.op = cnft_pkg::OP_MDAY_STEP;
                    n_state  = i_stat.mday_end ? cnft_pkg::S_MON : cnft_pkg::S_RET;
                end else begin
                    o_cmd.op = cnft_pkg::OP_FIND_MDAY;
                    if (i_stat.find_none) begin
                        n_fail  = 1'b1;
                        n_state = cnft_pkg::S_OUT;
                    end else if (i_stat.find_ovf) begin
                        n_state = cnft_pkg::S_MON;
                    end else begin
                        n_state = cnft_pkg::S_RET;
                    end
                end
            end
            cnft_pkg::S_MON: begin
                o_cmd.op = cnft_pkg::OP_FIND_MON;
                if (i_stat.find_none) begin
                    n_fail  = 1'b1;
                    n_state = cnft_pkg::S_OUT;
                end else if (i_stat.find_ovf) begin
                    n_state = cnft_pkg::S_YEAR;
                end else begin
                    n_state = cnft_pkg::S_RET;
                end
            end
            cnft_pkg::S_YEAR: begin
                o_cmd.op = cnft_pkg::OP_FIND_YEAR;
                if (i_stat.find_none || i_stat.find_ovf) begin
                    n_fail  = 1'b1;
                    n_state = cnft_pkg::S_OUT;
                end else begin
                    n_state = cnft_pkg::S_RET;
                end
            end
            cnft_pkg::S_WALK: begin
                o_cmd.op = cnft_pkg::OP_WALK;
                n_cnt    = r_cnt + 3'd1;
                if (i_stat.walk_ok || (r_cnt == 3'd7)) n_state = cnft_pkg::S_MAIN;
            end
            cnft_pkg::S_RET: begin
                n_state = r_day_act ? cnft_pkg::S_DAY : cnft_pkg::S_MAIN;
            end
            cnft_pkg::S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_fail         = 1'b0;
                    n_state        = cnft_pkg::S_IDLE;
                end
            end
            default: n_state = cnft_pkg::S_IDLE;
        endcase
    end

endmodule

[src/cnft_dp.sv]
module cnft_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    input  logic [31:0]    i_in_data,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [31:0]    o_out_data,
    output logic           o_out_never,
    input  cnft_pkg::t_cmd  i_cmd,
    output cnft_pkg::t_stat o_stat
);

    logic [59:0] r_min_set;
    logic [23:0] r_hour_set;
    logic [31:0] r_mday_set;
    logic [11:0] r_mon_set;
    logic [6:0]  r_wday_set;
    logic [63:0] r_year_lo;
    logic [63:0] r_year_hi;
    logic        r_mday_any;

    logic [5:0] r_min;
    logic [4:0] r_hour;
    logic [4:0] r_mday;
    logic [3:0] r_mon;
    logic [2:0] r_wday;
    logic [7:0] r_year;

    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_never;

    function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic [7:0] year);
        logic leap;
        leap = (year[1:0] == 2'b00) && (year != 8'd0) && (year != 8'd200);
        if (mon >= cnft_pkg::NUM_MON) return 5'd31;
        if ((mon == cnft_pkg::FEB) && leap) return 5'd29;
        return cnft_pkg::month_len(mon);
    endfunction

    function automatic logic day_match(input logic [4:0] mday, input logic [3:0] mon,
                                       input logic [7:0] year, input logic [2:0] wday,
                                       input logic any, input logic [31:0] mset,
                                       input logic [11:0] monset, input logic [127:0] yset,
                                       input logic [6:0] wset);
        logic md, mo, yr, wd;
        md = any || (mset[mday] && (mday != 5'd0));
        mo = (mon < cnft_pkg::NUM_MON) && monset[mon];
        yr = !year[7] && yset[year[6:0]];
        wd = (wday != 3'd7) && wset[wday];
        return (md && mo && yr) || wd;
    endfunction

    // shared find-next-set-bit unit
    logic [127:0] w_mask, w_ge, w_above, w_pick, w_iso;
    logic [7:0]   w_v;
    logic [8:0]   w_sh;
    logic [6:0]   w_idx;
    logic [127:0] w_yset;

    assign w_yset = {r_year_hi, r_year_lo};

    always_comb begin
        w_mask = '0;
        w_v    = '0;
        unique case (i_cmd.op)
            cnft_pkg::OP_FIND_MIN:  begin w_mask = {68'd0, r_min_set};  w_v = {2'd0, r_min};  end
            cnft_pkg::OP_FIND_HOUR: begin w_mask = {104'd0, r_hour_set}; w_v = {3'd0, r_hour}; end
            cnft_pkg::OP_FIND_MDAY: begin
                w_mask = {96'd0, r_mday_set[31:1], 1'b0};
                w_v    = {3'd0, r_mday};
            end
            cnft_pkg::OP_FIND_MON:  begin w_mask = {116'd0, r_mon_set}; w_v = {4'd0, r_mon}; end
            cnft_pkg::OP_FIND_YEAR: begin w_mask = w_yset; w_v = r_year; end
            default: ;
        endcase
        w_sh    = {1'b0, w_v} + 9'd1;
        w_ge    = (w_sh > 9'd127) ? '0 : ({128{1'b1}} << w_sh[6:0]);
        w_above = w_mask & w_ge;
        w_pick  = (w_above == '0) ? w_mask : w_above;
        w_iso   = w_pick & (~w_pick + 128'd1);
        w_idx   = '0;
        for (int i = 0; i < 128; i++) begin
            if (w_iso[i]) w_idx = w_idx | 7'(i);
        end
    end

    // one day forward for the weekday walk
    logic [4:0] w_ld, s_mday;
    logic [3:0] s_mon;
    logic [7:0] s_year;
    logic [2:0] s_wday;

    always_comb begin
        w_ld   = days_in_month(r_mon, r_year);
        s_wday = (r_wday >= cnft_pkg::LAST_WDAY[2:0]) ? 3'd0 : r_wday + 3'd1;
        s_mon  = r_mon;
        s_year = r_year;
        if (r_mday >= w_ld) begin
            s_mday = 5'd1;
            if (r_mon >= cnft_pkg::DEC) begin
                s_mon  = 4'd0;
                s_year = r_year + 8'd1;
            end else begin
                s_mon = r_mon + 4'd1;
            end
        end else begin
            s_mday = r_mday + 5'd1;
        end
    end

    always_comb begin
        o_stat.find_none = (w_mask == '0);
        o_stat.find_ovf  = (w_above == '0);
        o_stat.day_ok    = day_match(r_mday, r_mon, r_year, r_wday, r_mday_any, r_mday_set,
                                     r_mon_set, w_yset, r_wday_set);
        o_stat.hour_hit  = r_hour_set[r_hour] && (r_hour < 5'd24);
        o_stat.min_hit   = (r_min < 6'd60) && r_min_set[r_min];
        o_stat.year_ok   = !r_year[7] && w_yset[r_year[6:0]];
        o_stat.mon_ok    = (r_mon < cnft_pkg::NUM_MON) && r_mon_set[r_mon];
        o_stat.mday_ok   = r_mday_any || (r_mday_set[r_mday] && (r_mday != 5'd0));
        o_stat.wday_used = (r_wday_set != '0);
        o_stat.mday_any  = r_mday_any;
        o_stat.mday_end  = (r_mday >= w_ld);
        o_stat.walk_ok   = day_match(s_mday, s_mon, s_year, s_wday, r_mday_any, r_mday_set,
                                     r_mon_set, w_yset, r_wday_set);
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_set  <= '0;
            r_hour_set <= '0;
            r_mday_set <= '0;
            r_mon_set  <= '0;
            r_wday_set <= '0;
            r_year_lo  <= '0;
            r_year_hi  <= '0;
            r_mday_any <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cnft_pkg::REG_MINUTE:    r_min_set  <= i_cfg_data[59:0];
                cnft_pkg::REG_HOUR:      r_hour_set <= i_cfg_data[23:0];
                cnft_pkg::REG_MDAY:      r_mday_set <= i_cfg_data[31:0];
                cnft_pkg::REG_MONTH:     r_mon_set  <= i_cfg_data[11:0];
                cnft_pkg::REG_WDAY:      r_wday_set <= i_cfg_data[6:0];
                cnft_pkg::REG_YEAR_LOW:  r_year_lo  <= i_cfg_data;
                cnft_pkg::REG_YEAR_HIGH: r_year_hi  <= i_cfg_data;
                cnft_pkg::REG_MDAY_ANY:  r_mday_any <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            cnft_pkg::OP_LOAD: begin
                r_min  <= i_in_data[5:0];
                r_hour <= i_in_data[10:6];
                r_mday <= i_in_data[15:11];
                r_mon  <= i_in_data[19:16];
                r_wday <= i_in_data[22:20];
                r_year <= {1'b0, i_in_data[29:23]};
            end
            cnft_pkg::OP_FIND_MIN:  if (!o_stat.find_none) r_min  <= w_idx[5:0];
            cnft_pkg::OP_FIND_HOUR: if (!o_stat.find_none) r_hour <= w_idx[4:0];
            cnft_pkg::OP_FIND_MDAY: if (!o_stat.find_none) r_mday <= w_idx[4:0];
            cnft_pkg::OP_FIND_MON:  if (!o_stat.find_none) r_mon  <= w_idx[3:0];
            cnft_pkg::OP_FIND_YEAR: if (!o_stat.find_none) r_year <= {1'b0, w_idx};
            cnft_pkg::OP_CLR_HM: begin
                r_hour <= '0;
                r_min  <= '0;
            end
            cnft_pkg::OP_CLR_MIN:  r_min <= '0;
            cnft_pkg::OP_SET_JAN1: begin
                r_mon  <= '0;
                r_mday <= 5'd1;
            end
            cnft_pkg::OP_SET_D1:   r_mday <= 5'd1;
            cnft_pkg::OP_MDAY_STEP: r_mday <= o_stat.mday_end ? 5'd1 : r_mday + 5'd1;
            cnft_pkg::OP_WALK: begin
                r_wday <= s_wday;
                r_mday <= s_mday;
                r_mon  <= s_mon;
                r_year <= s_year;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_never <= i_cmd.never;
            r_out_data  <= i_cmd.never ? '0 :
                           {4'd0, r_year, r_mon, r_mday, r_hour, r_min};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_never = r_out_never;

endmodule

[src/cron_next_fire_time.sv]
// cron next fire time: the sequencer walks the minute, hour, day, month and year carry
// chain one unit per step, plus up to eight single-day steps of the weekday walk; a new
// result waits while an earlier result is held back
// throughput: one item at a time, next beat taken once the result is registered
// reset: synchronous active low, clears all schedule registers and the sequencer
module cron_next_fire_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // minute[5:0] hour[10:6] mday[15:11] month[19:16] wday[22:20] year[29:23]
    input  logic [31:0] i_s_axis_tdata,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // minute[5:0] hour[10:6] mday[15:11] month[19:16] year[27:20]
    output logic [31:0] o_m_axis_tdata,
    // never[0]
    output logic [0:0]  o_m_axis_tuser
);

    cnft_pkg::t_cmd  w_cmd;
    cnft_pkg::t_stat w_stat;
    logic            w_ready;
    logic            w_never;

    // the sequencer only takes a beat when idle
    assign o_s_axis_tready = w_ready;

    cnft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_s_axis_tvalid),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // schedule registers, time fields, find unit and result register
    cnft_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_never (w_never),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    assign o_m_axis_tuser = w_never;

endmodule
